>>> sv/multi_click_button_decoder_core_assert.svh
// Assertion macros used by the button decoder top level.
`ifndef MULTI_CLICK_BUTTON_DECODER_CORE_ASSERT_SVH
`define MULTI_CLICK_BUTTON_DECODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Checked on every rising edge of clk outside reset.
`define MCBD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("mcbd check failed");
// Checked on every rising edge of clk, reset included.
`define MCBD_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("mcbd reset check failed");
`else
`define MCBD_ASSERT(lbl, prop)
`define MCBD_ASSERT_RST(lbl, prop)
`endif
`endif

>>> sv/mcbd_pkg.sv
// Types and constants of the multi-click button decoder.
`default_nettype none
package mcbd_pkg;

  localparam int HOLD_W   = 13;
  localparam int MULT_W   = 14;
  localparam int DROP_W   = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int LONG_STEPS = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_MIN       = 3'd0,
    REG_LONG_TICKS      = 3'd1,
    REG_SETTLE_TICKS    = 3'd2,
    REG_TOP_MODE        = 3'd3,
    REG_BRIGHTNESS_STEP = 3'd4
  } cfg_index_t;

  localparam logic [7:0] CLICKS_NEXT_MODE = 8'd1;
  localparam logic [7:0] CLICKS_LIGHTS    = 8'd2;
  localparam logic [7:0] CLICKS_TOP_MODE  = 8'd3;

  localparam logic [7:0] FULL_BRIGHTNESS = 8'd255;

  localparam logic [7:0] RST_SHORT_MIN       = 8'd5;
  localparam logic [9:0] RST_LONG_TICKS      = 10'd100;
  localparam logic [7:0] RST_SETTLE_TICKS    = 8'd50;
  localparam logic [2:0] RST_TOP_MODE        = 3'd4;
  localparam logic [7:0] RST_BRIGHTNESS_STEP = 8'd51;

  typedef struct packed {
    logic [7:0] short_min;
    logic [9:0] long_ticks;
    logic [7:0] settle_ticks;
    logic [2:0] top_mode;
    logic [7:0] brightness_step;
  } cfg_t;

  typedef struct packed {
    logic [HOLD_W-1:0] hold_count;
    logic [7:0]        click_count;
    logic              group_pending;
    logic [7:0]        settle_count;
    logic [2:0]        mode;
    logic [7:0]        brightness;
    logic              lights;
  } state_t;

endpackage
`default_nettype wire

>>> sv/mcbd_cfg.sv
// Configuration register file of the button decoder.
`default_nettype none
module mcbd_cfg
  import mcbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_min       <= RST_SHORT_MIN;
      cfg.long_ticks      <= RST_LONG_TICKS;
      cfg.settle_ticks    <= RST_SETTLE_TICKS;
      cfg.top_mode        <= RST_TOP_MODE;
      cfg.brightness_step <= RST_BRIGHTNESS_STEP;
    end else if (cfg_valid && cfg_ready) begin
      // Indexes past the register list are dropped.
      unique case (cfg_index)
        REG_SHORT_MIN:       cfg.short_min       <= cfg_data[7:0];
        REG_LONG_TICKS:      cfg.long_ticks      <= cfg_data[9:0];
        REG_SETTLE_TICKS:    cfg.settle_ticks    <= cfg_data[7:0];
        REG_TOP_MODE:        cfg.top_mode        <= cfg_data[2:0];
        REG_BRIGHTNESS_STEP: cfg.brightness_step <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/mcbd_step.sv
// Next-state logic for one polling tick of the button decoder.
`default_nettype none
module mcbd_step
  import mcbd_pkg::*;
(
  input  cfg_t   cfg,
  input  state_t st,
  input  logic   sample_before,
  input  logic   sample_after,
  output state_t st_next,
  output logic   toggled
);

  logic [MULT_W-1:0] mult [1:LONG_STEPS+1];
  logic [LONG_STEPS-1:0] in_band;
  logic [MULT_W-1:0] hold_x;
  logic [HOLD_W-1:0] hold_upd;

  // Multiples of the long press time; each is a constant-times-L product.
  always_comb begin
    for (int k = 1; k <= LONG_STEPS + 1; k++) begin
      mult[k] = MULT_W'(k) * {{(MULT_W-10){1'b0}}, cfg.long_ticks};
    end
  end

  // Hold count after the sample update, used for the band compares.
  always_comb begin
    hold_upd = st.hold_count;
    if (sample_before && sample_after) begin
      hold_upd = st.hold_count + 1'b1;
    end else if (sample_before) begin
      hold_upd = '0;
    end
  end

  assign hold_x = {1'b0, hold_upd};

  always_comb begin
    for (int i = 0; i < LONG_STEPS; i++) begin
      in_band[i] = (hold_x >= mult[i+1]) && (hold_x < mult[i+2]);
    end
  end

  function automatic logic [7:0] step_level(input int unsigned i, input logic [7:0] step);
    logic [DROP_W-1:0] drop;
    drop = DROP_W'(i) * {{(DROP_W-8){1'b0}}, step};
    if (drop >= {{(DROP_W-8){1'b0}}, FULL_BRIGHTNESS}) begin
      step_level = 8'd0;
    end else begin
      step_level = FULL_BRIGHTNESS - drop[7:0];
    end
  endfunction

  always_comb begin
    logic hit;
    st_next = st;
    toggled = 1'b0;
    hit     = 1'b0;

    // Falling edge: a hold between the two limits is one click.
    if (sample_before && !sample_after) begin
      if ((st.hold_count > {{(HOLD_W-8){1'b0}}, cfg.short_min}) &&
          (st.hold_count < {{(HOLD_W-10){1'b0}}, cfg.long_ticks})) begin
        st_next.click_count   = st.click_count + 1'b1;
        st_next.group_pending = 1'b1;
        st_next.settle_count  = '0;
      end
    end
    st_next.hold_count = hold_upd;

    // Long press: cancel the group, then set brightness by hold length.
    // The first band wins over the wrap at seven long times, which in
    // turn wins over the upper bands.
    if (hold_x >= {{(MULT_W-10){1'b0}}, cfg.long_ticks}) begin
      st_next.group_pending = 1'b0;
      st_next.click_count   = '0;
      st_next.settle_count  = '0;
      priority if (in_band[0]) begin
        st_next.brightness = FULL_BRIGHTNESS;
      end else if (hold_x == mult[LONG_STEPS]) begin
        st_next.hold_count = '0;
      end else begin
        for (int i = 1; i < LONG_STEPS; i++) begin
          if (!hit && in_band[i]) begin
            hit = 1'b1;
            st_next.brightness = step_level(i, cfg.brightness_step);
          end
        end
      end
    end

    // Settle timer after release; decode the group when it expires.
    if (st_next.group_pending && (st_next.hold_count == '0)) begin
      st_next.settle_count = st_next.settle_count + 1'b1;
      if (st_next.settle_count == cfg.settle_ticks) begin
        unique case (st_next.click_count)
          CLICKS_NEXT_MODE: begin
            st_next.mode = (st.mode == cfg.top_mode) ? 3'd0 : st.mode + 1'b1;
          end
          CLICKS_LIGHTS: begin
            st_next.lights = !st.lights;
            toggled = 1'b1;
          end
          CLICKS_TOP_MODE: begin
            st_next.mode = cfg.top_mode;
          end
          default: ;
        endcase
        st_next.group_pending = 1'b0;
        st_next.click_count   = '0;
        st_next.settle_count  = '0;
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/multi_click_button_decoder_core.sv
// Top level of the multi-click and long-press button decoder.
//
// Each input item on the s_ stream is one polling tick carrying two button
// samples, one read before and one after the tick delay. For every item the
// block returns exactly one result item on the m_ stream with the mode, the
// brightness, the lights flag and a pulse that marks a lights toggle.
// Settings are written over the cfg_ channel (index and data), which is
// always ready; writes are expected only while no tick is in flight.
//
// An item is taken into an input register, and from there the state update
// runs through one pass of compare and counter logic into the state
// registers and the output register (two register stages from s_tdata to
// m_tdata). One item per cycle is sustained while the receiver keeps m_tready
// high. When the receiver stalls, the result holds in the output register
// and the input register still takes one more item; after that s_tready
// drops until the output drains.
// Synchronous reset empties both registers, loads the default settings, and
// sets mode 0, full brightness and lights off.
`default_nettype none
`include "multi_click_button_decoder_core_assert.svh"
module multi_click_button_decoder_core
  import mcbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Input ticks. s_tdata: [0] sample_before, [1] sample_after, [7:2] zero.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,
  // Results. m_tdata: [2:0] mode, [10:3] brightness, [11] lights_on,
  // [12] lights_toggled, [15:13] zero.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg;
  state_t state;
  state_t state_next;
  logic   toggled_next;

  logic   s1_valid;
  logic   s1_before;
  logic   s1_after;
  logic   advance;
  logic   load;

  logic [2:0] out_mode;
  logic [7:0] out_brightness;
  logic       out_lights;
  logic       out_toggled;

  mcbd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mcbd_step u_step (
    .cfg           (cfg),
    .st            (state),
    .sample_before (s1_before),
    .sample_after  (s1_after),
    .st_next       (state_next),
    .toggled       (toggled_next)
  );

  // The output register frees up when it is empty or being read.
  assign advance  = !m_tvalid || m_tready;
  assign load     = s1_valid && advance;
  assign s_tready = !s1_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_before <= s_tdata[0];
      s1_after  <= s_tdata[1];
    end
  end

  // Decoder state, updated once per processed tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.hold_count    <= '0;
      state.click_count   <= '0;
      state.group_pending <= 1'b0;
      state.settle_count  <= '0;
      state.mode          <= '0;
      state.brightness    <= FULL_BRIGHTNESS;
      state.lights        <= 1'b0;
    end else if (load) begin
      state <= state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_mode       <= state_next.mode;
      out_brightness <= state_next.brightness;
      out_lights     <= state_next.lights;
      out_toggled    <= toggled_next;
    end
  end

  assign m_tdata = {3'b000, out_toggled, out_lights, out_brightness, out_mode};

  // Reset leaves both pipeline registers empty.
  `MCBD_ASSERT_RST(a_reset_empties, rst |=> (!s1_valid && !m_tvalid))
  // Without a pending group, the click and settle counters are idle.
  `MCBD_ASSERT(a_idle_group, !state.group_pending |-> (state.click_count == '0 && state.settle_count == '0))
  // A toggle pulse comes with a real change of the lights flag.
  `MCBD_ASSERT(a_toggle_flips, (load && toggled_next) |=> (state.lights != $past(state.lights)))

endmodule
`default_nettype wire

>>> tb/multi_click_button_decoder_core_test.sv
// Self-checking testbench of the multi-click and long-press button decoder.
`timescale 1ns / 100ps
module multi_click_button_decoder_core_test;
  import mcbd_pkg::*;

  // Two register stages from an accepted tick to its result item.
  localparam int PIPE_LATENCY = 2;
  // The slowest correct run is roughly 900 ticks.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Mismatch reports stop after this many lines; failures are still counted.
  localparam int REPORT_CAP = 200;
  localparam int RANDOM_TICKS = 100;

  // One result item, laid out as in m_tdata with mode in the lowest bits.
  typedef struct packed {
    logic       lights_toggled;
    logic       lights_on;
    logic [7:0] brightness;
    logic [2:0] mode;
  } result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [15:0]           m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  multi_click_button_decoder_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Shadow copy of the decoder: settings and state as the block should hold them.
  cfg_t              cfg_now;
  logic [HOLD_W-1:0] hold_ticks;
  logic [7:0]        click_tally;
  logic              group_open;
  logic [7:0]        settle_seen;
  logic [2:0]        mode_now;
  logic [7:0]        brightness_now;
  logic              lights_now;

  // Results predicted for accepted ticks, oldest first.
  result_t predicted_outputs[$];

  int error_count = 0;
  int report_count = 0;
  int ticks_sent = 0;
  int cycle_count = 0;
  // Upper bounds of the random idle cycles drawn per item on each side.
  int tx_max_gap = 9;
  int rx_max_gap = 9;
  // A nonzero value asks the receiver for one long hold-off of that many cycles.
  int rx_holdoff = 0;

  function automatic void reset_model();
    cfg_now.short_min       = RST_SHORT_MIN;
    cfg_now.long_ticks      = RST_LONG_TICKS;
    cfg_now.settle_ticks    = RST_SETTLE_TICKS;
    cfg_now.top_mode        = RST_TOP_MODE;
    cfg_now.brightness_step = RST_BRIGHTNESS_STEP;
    hold_ticks     = '0;
    click_tally    = '0;
    group_open     = 1'b0;
    settle_seen    = '0;
    mode_now       = '0;
    brightness_now = FULL_BRIGHTNESS;
    lights_now     = 1'b0;
  endfunction

  // Advances the shadow state by one polling tick and returns the result item.
  function automatic result_t decode_tick(input logic pre_delay, input logic post_delay);
    result_t r;
    logic    toggled;
    logic    done;
    int      i;
    int      lo;
    int      hi;
    int      drop;
    int      hold_v;
    int      span;
    toggled = 1'b0;
    // Stage one: count the hold, or close it on a falling edge.
    if (pre_delay && post_delay) begin
      hold_ticks = hold_ticks + 1'b1;
    end else if (pre_delay) begin
      if (hold_ticks > cfg_now.short_min && hold_ticks < cfg_now.long_ticks) begin
        click_tally = click_tally + 1'b1;
        group_open  = 1'b1;
        settle_seen = '0;
      end
      hold_ticks = '0;
    end
    // Stage two: a long hold drops the click group and scales the brightness, or clears the hold at seven long times.
    if (hold_ticks >= cfg_now.long_ticks) begin
      group_open  = 1'b0;
      click_tally = '0;
      settle_seen = '0;
      done   = 1'b0;
      span   = int'(cfg_now.long_ticks);
      hold_v = int'(hold_ticks);
      for (i = 0; i < LONG_STEPS; i++) begin
        if (!done) begin
          lo = (i + 1) * span;
          hi = (i + 2) * span;
          if (hold_v >= lo && hold_v < hi) begin
            drop = i * int'(cfg_now.brightness_step);
            brightness_now = (drop >= int'(FULL_BRIGHTNESS)) ? 8'd0
                                                             : 8'(int'(FULL_BRIGHTNESS) - drop);
            done = 1'b1;
          end else if (hold_v == LONG_STEPS * span) begin
            hold_ticks = '0;
            done = 1'b1;
          end
        end
      end
    end
    // Stage three: idle ticks after the last click close the group and decode it.
    if (group_open && hold_ticks == '0) begin
      settle_seen = settle_seen + 1'b1;
      if (settle_seen == cfg_now.settle_ticks) begin
        if (click_tally == CLICKS_NEXT_MODE) begin
          mode_now = (mode_now == cfg_now.top_mode) ? 3'd0 : mode_now + 3'd1;
        end else if (click_tally == CLICKS_LIGHTS) begin
          lights_now = ~lights_now;
          toggled = 1'b1;
        end else if (click_tally == CLICKS_TOP_MODE) begin
          mode_now = cfg_now.top_mode;
        end
        group_open  = 1'b0;
        click_tally = '0;
        settle_seen = '0;
      end
    end
    r.mode           = mode_now;
    r.brightness     = brightness_now;
    r.lights_on      = lights_now;
    r.lights_toggled = toggled;
    return r;
  endfunction

  // Offers one tick after a random gap; the prediction is made at acceptance.
  task automatic send_tick(input logic pre_delay, input logic post_delay);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, post_delay, pre_delay};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted_outputs.push_back(decode_tick(pre_delay, post_delay));
    ticks_sent++;
  endtask

  task automatic press(input int n);
    repeat (n) send_tick(1'b1, 1'b1);
  endtask

  // Falling edge: pressed before the delay, released after it.
  task automatic button_up();
    send_tick(1'b1, 1'b0);
  endtask

  task automatic idle_ticks(input int n);
    repeat (n) send_tick(1'b0, 1'b0);
  endtask

  task automatic click(input int hold);
    press(hold);
    button_up();
  endtask

  // A group of equal clicks followed by enough idle ticks to decode it.
  task automatic click_group(input int clicks, input int hold);
    repeat (clicks) begin
      click(hold);
      idle_ticks(1);
    end
    idle_ticks(int'(cfg_now.settle_ticks) + 1);
  endtask

  // Stops offering ticks until every predicted result has come back, then lets
  // the pipeline settle so that a following register write finds it idle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (predicted_outputs.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 1) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SHORT_MIN:       cfg_now.short_min       = data[7:0];
      REG_LONG_TICKS:      cfg_now.long_ticks      = data[9:0];
      REG_SETTLE_TICKS:    cfg_now.settle_ticks    = data[7:0];
      REG_TOP_MODE:        cfg_now.top_mode        = data[2:0];
      REG_BRIGHTNESS_STEP: cfg_now.brightness_step = data[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input int short_min, input int long_ticks, input int settle,
                              input int top, input int step);
    drain();
    write_reg(REG_SHORT_MIN, 10'(short_min));
    write_reg(REG_LONG_TICKS, 10'(long_ticks));
    write_reg(REG_SETTLE_TICKS, 10'(settle));
    write_reg(REG_TOP_MODE, 10'(top));
    write_reg(REG_BRIGHTNESS_STEP, 10'(step));
    cfg_valid <= 1'b0;
  endtask

  // Receiver: stalls at random before each result item and checks it.
  task automatic report_mismatch(input string field, input int want, input int got);
    error_count++;
    if (report_count < REPORT_CAP) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      report_count++;
    end
  endtask

  initial begin : result_checker
    int      stall;
    result_t want;
    result_t got;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_holdoff > 0) begin
        stall = rx_holdoff;
        rx_holdoff = 0;
      end else begin
        stall = $urandom_range(0, rx_max_gap);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got = m_tdata[12:0];
      if (predicted_outputs.size() == 0) begin
        error_count++;
        if (report_count < REPORT_CAP) begin
          $display("%0t: result item with none predicted, expected nothing, actual %h",
                   $time, m_tdata);
          report_count++;
        end
      end else begin
        want = predicted_outputs.pop_front();
        if (got.mode !== want.mode)
          report_mismatch("mode", int'(want.mode), int'(got.mode));
        if (got.brightness !== want.brightness)
          report_mismatch("brightness", int'(want.brightness), int'(got.brightness));
        if (got.lights_on !== want.lights_on)
          report_mismatch("lights_on", int'(want.lights_on), int'(got.lights_on));
        if (got.lights_toggled !== want.lights_toggled)
          report_mismatch("lights_toggled", int'(want.lights_toggled),
                          int'(got.lights_toggled));
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** multi_click_button_decoder_core: FAILED **");
    $finish;
  end

  // Default settings straight out of reset, with idle and rising-edge ticks.
  task automatic test_reset_state();
    idle_ticks(3);
    send_tick(1'b0, 1'b1);
    idle_ticks(2);
  endtask

  // Ignored indexes, and writes wider than the register that must be masked.
  task automatic test_config_port();
    drain();
    write_reg(3'd5, 10'h3FF);
    write_reg(3'd6, 10'h2AA);
    write_reg(3'd7, 10'h155);
    write_reg(REG_SHORT_MIN, 10'h3FF);
    write_reg(REG_LONG_TICKS, 10'h3FF);
    write_reg(REG_SETTLE_TICKS, 10'h3FF);
    write_reg(REG_TOP_MODE, 10'h3FF);
    write_reg(REG_BRIGHTNESS_STEP, 10'h3FF);
    cfg_valid <= 1'b0;
    click(20);
    idle_ticks(5);
  endtask

  // Single, double, triple and quadruple clicks, taps too short to count,
  // holds at both click limits, and glitch ticks inside a hold.
  task automatic test_click_decode();
    apply_config(2, 12, 5, 3, 51);
    click(2);
    idle_ticks(7);
    click_group(1, 3);
    click_group(1, 11);
    click_group(1, 4);
    // The mode equals top_mode here, so the next single click wraps it to 0.
    click_group(1, 5);
    click_group(2, 3);
    click_group(2, 6);
    click_group(3, 4);
    click_group(4, 3);
    // A rising edge and an idle tick in the middle leave the hold count alone.
    press(3);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    press(2);
    button_up();
    idle_ticks(6);
    // A hold that reaches long_ticks is not a click.
    click(3);
    idle_ticks(1);
    click(12);
    idle_ticks(6);
  endtask

  // A mode above top_mode advances and wraps within three bits.
  task automatic test_mode_above_top();
    apply_config(1, 8, 2, 3, 51);
    click_group(3, 3);
    apply_config(1, 8, 2, 1, 51);
    click_group(1, 3);
    apply_config(1, 8, 2, 0, 51);
    repeat (4) click_group(1, 2);
  endtask

  // Brightness steps of a long hold, the clear at seven steps, the floor at 0,
  // a zero step, and pending clicks cancelled by a long hold.
  task automatic test_long_press();
    apply_config(1, 4, 1, 7, 51);
    click(2);
    press(34);
    button_up();
    idle_ticks(3);
    apply_config(1, 4, 1, 7, 255);
    click(12);
    idle_ticks(2);
    apply_config(1, 4, 1, 7, 0);
    click(20);
    idle_ticks(2);
  endtask

  // long_ticks of 1 and of 0: every hold is long, and with 0 every tick
  // cancels the click group.
  task automatic test_tiny_long_time();
    apply_config(0, 1, 3, 5, 40);
    click(1);
    idle_ticks(2);
    click(9);
    idle_ticks(4);
    apply_config(0, 0, 3, 5, 40);
    click(1);
    idle_ticks(4);
    click(6);
    idle_ticks(3);
  endtask

  // settle_ticks of 0: the group ends only when the settle count wraps.
  task automatic test_zero_settle();
    tx_max_gap = 0;
    rx_max_gap = 0;
    apply_config(1, 10, 0, 7, 51);
    click(3);
    idle_ticks(258);
    tx_max_gap = 9;
    rx_max_gap = 9;
  endtask

  // A hold through the brightness steps short of the clear at seven steps;
  // then long_ticks shrinks below the running hold, which misses the clear
  // point and counts on.
  task automatic test_hold_wrap();
    apply_config(5, 4, 50, 4, 20);
    press(27);
    apply_config(5, 2, 50, 4, 20);
    press(12);
    button_up();
    idle_ticks(3);
  endtask

  // The receiver holds off for a long stretch while ticks keep coming, so the
  // block fills and drops s_tready.
  task automatic test_output_backpressure();
    int i;
    apply_config(1, 6, 3, 5, 30);
    tx_max_gap = 0;
    rx_holdoff = 200;
    for (i = 0; i < 40; i++) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    tx_max_gap = 9;
  endtask

  // The sender stops until all results are back, in the middle of a group.
  task automatic test_sender_pause();
    apply_config(1, 6, 4, 6, 30);
    click(3);
    idle_ticks(1);
    drain();
    click(2);
    drain();
    idle_ticks(6);
  endtask

  // Random settings per phase; mostly well-formed gestures with random lengths,
  // mixed with taps, long holds, idle runs and noise.
  task automatic test_random_gestures();
    int start;
    int phase_start;
    int span;
    int short_v;
    int kind;
    int n;
    start = ticks_sent;
    while (ticks_sent - start < RANDOM_TICKS) begin
      short_v = $urandom_range(0, 6);
      span = ($urandom_range(0, 7) == 0) ? $urandom_range(2, short_v + 2)
                                         : short_v + $urandom_range(2, 18);
      apply_config(short_v, span, $urandom_range(1, 12), $urandom_range(0, 7),
                   $urandom_range(0, 255));
      tx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 9;
      rx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 9;
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < 50) begin
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
          if (int'(cfg_now.short_min) + 1 <= int'(cfg_now.long_ticks) - 1)
            n = $urandom_range(int'(cfg_now.short_min) + 1, int'(cfg_now.long_ticks) - 1);
          else
            n = $urandom_range(1, int'(cfg_now.long_ticks) + 1);
          click(n);
          idle_ticks($urandom_range(0, 3));
        end else if (kind < 55) begin
          click($urandom_range(0, int'(cfg_now.short_min)));
        end else if (kind < 65) begin
          click($urandom_range(int'(cfg_now.long_ticks), 8 * int'(cfg_now.long_ticks) + 2));
        end else if (kind < 80) begin
          idle_ticks($urandom_range(0, int'(cfg_now.settle_ticks) + 3));
        end else begin
          repeat ($urandom_range(1, 6))
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end
    end
    tx_max_gap = 9;
    rx_max_gap = 9;
  endtask

  initial begin
    reset_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_config_port();
    test_click_decode();
    test_mode_above_top();
    test_long_press();
    test_tiny_long_time();
    test_zero_settle();
    test_hold_wrap();
    test_output_backpressure();
    test_sender_pause();
    test_random_gestures();
    // Wait out every predicted result, then watch a little longer for strays.
    drain();
    repeat (PIPE_LATENCY + 2) @(posedge clk);
    if (error_count == 0 && predicted_outputs.size() == 0) begin
      $display("** multi_click_button_decoder_core: PASSED **");
    end else begin
      $display("** multi_click_button_decoder_core: FAILED **");
    end
    $finish;
  end

endmodule
